// ----- hdl/xcrc_pkg.sv -----
// shared types, protocol constants and helper functions for the xmodem crc receiver
package xcrc_pkg;

  localparam int BUFFER_BYTES_DEF = 65536;

  // result queue
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);
  localparam int MAX_RES  = 3;

  // link characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // input kinds
  localparam logic [1:0] IK_BYTE  = 2'd0;
  localparam logic [1:0] IK_TICK  = 2'd1;
  localparam logic [1:0] IK_START = 2'd2;

  // result kinds
  localparam logic [1:0] RK_TX     = 2'd0;
  localparam logic [1:0] RK_WRITE  = 2'd1;
  localparam logic [1:0] RK_FINISH = 2'd2;

  // session status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_CANCEL   = 3'd2;
  localparam logic [2:0] ST_RETRIES  = 3'd3;
  localparam logic [2:0] ST_SEQ_ERR  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_CAPACITY   = 2'd0;
  localparam logic [1:0] CFG_BYTE_TO    = 2'd1;
  localparam logic [1:0] CFG_CANCEL_TO  = 2'd2;
  localparam logic [1:0] CFG_MAX_RETRY  = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_CANCEL,
    PH_PACKET
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  tx_byte;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic [2:0]  status;
    logic [16:0] length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [16:0] buffer_capacity;
    logic [15:0] byte_timeout_ticks;
    logic [15:0] cancel_timeout_ticks;
    logic [7:0]  max_retries;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic out_item_t mk_tx(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.result_kind = RK_TX;
    r.tx_byte = b;
    return r;
  endfunction

  function automatic out_item_t mk_write(input logic [15:0] addr, input logic [7:0] data);
    out_item_t r;
    r = '0;
    r.result_kind = RK_WRITE;
    r.write_addr = addr;
    r.write_data = data;
    return r;
  endfunction

  function automatic out_item_t mk_finish(input logic [2:0] st, input logic [16:0] len);
    out_item_t r;
    r = '0;
    r.result_kind = RK_FINISH;
    r.status = st;
    r.length = len;
    return r;
  endfunction

endpackage

// ----- hdl/xcrc_core.sv -----
// receiver protocol state and per-transfer result generation
module xcrc_core
  import xcrc_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 proc,
  input  in_item_t             item,
  input  cfg_t                 cfg,
  output logic [1:0]           res_cnt,
  output out_item_t [MAX_RES-1:0] res
);

  localparam logic [31:0] BUF_LIM = 32'(BUFFER_BYTES);

  phase_t      phase_r, phase_nxt;
  logic        started_r, started_nxt;
  logic [7:0]  retry_r, retry_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [7:0]  exp_seq_r, exp_seq_nxt;
  logic [16:0] committed_r, committed_nxt;
  logic        long_r, long_nxt;
  logic [10:0] pidx_r, pidx_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  inv_r, inv_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;

  logic [16:0] cap;
  assign cap = ({15'd0, cfg.buffer_capacity} > BUF_LIM) ? BUF_LIM[16:0] : cfg.buffer_capacity;

  always_comb begin
    logic [1:0]  n;
    logic [8:0]  retry_inc;
    logic        retry_over;
    logic [15:0] lim;
    logic [15:0] idle_inc;
    logic [10:0] blk;
    logic [17:0] addr_full;
    logic [16:0] room;
    logic [16:0] take;
    logic [16:0] new_len;
    logic [7:0]  b;

    n = '0;
    res = '0;
    b = item.rx_byte;
    phase_nxt = phase_r;
    started_nxt = started_r;
    retry_nxt = retry_r;
    idle_nxt = idle_r;
    exp_seq_nxt = exp_seq_r;
    committed_nxt = committed_r;
    long_nxt = long_r;
    pidx_nxt = pidx_r;
    seq_nxt = seq_r;
    inv_nxt = inv_r;
    crc_nxt = crc_r;
    crc_hi_nxt = crc_hi_r;

    retry_inc = {1'b0, retry_r} + 9'd1;
    retry_over = retry_inc > {1'b0, cfg.max_retries};
    lim = (phase_r == PH_CANCEL) ? cfg.cancel_timeout_ticks : cfg.byte_timeout_ticks;
    idle_inc = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;
    blk = long_r ? 11'd1024 : 11'd128;
    addr_full = {1'b0, committed_r} + 18'(pidx_r - 11'd2);
    room = (committed_r < cap) ? cap - committed_r : 17'd0;
    take = (17'(blk) < room) ? 17'(blk) : room;
    new_len = committed_r + take;

    if (proc) begin
      case (item.kind)
        IK_START: begin
          started_nxt = 1'b0;
          retry_nxt = '0;
          exp_seq_nxt = 8'd1;
          committed_nxt = '0;
          pidx_nxt = '0;
          crc_nxt = '0;
          phase_nxt = PH_HEADER;
          idle_nxt = '0;
          res[n] = mk_tx(CH_C);
          n = n + 2'd1;
        end
        IK_TICK: begin
          if (phase_r != PH_IDLE) begin
            idle_nxt = idle_inc;
            if (idle_inc >= lim) begin
              idle_nxt = '0;
              case (phase_r)
                PH_HEADER: begin
                  if (retry_over) begin
                    phase_nxt = PH_IDLE;
                    res[n] = mk_finish(ST_TIMEOUT, committed_r);
                    n = n + 2'd1;
                  end else begin
                    retry_nxt = retry_inc[7:0];
                    if (!started_r) begin
                      res[n] = mk_tx(CH_C);
                      n = n + 2'd1;
                    end
                  end
                end
                PH_CANCEL: begin
                  phase_nxt = PH_HEADER;
                  if (!started_r) begin
                    res[n] = mk_tx(CH_C);
                    n = n + 2'd1;
                  end
                end
                default: begin
                  res[n] = mk_tx(CH_NAK);
                  n = n + 2'd1;
                  phase_nxt = PH_HEADER;
                  if (retry_over) begin
                    phase_nxt = PH_IDLE;
                    res[n] = mk_finish(ST_RETRIES, committed_r);
                    n = n + 2'd1;
                  end else begin
                    retry_nxt = retry_inc[7:0];
                  end
                end
              endcase
            end
          end
        end
        IK_BYTE: begin
          case (phase_r)
            PH_HEADER: begin
              idle_nxt = '0;
              if (b == CH_EOT) begin
                res[n] = mk_tx(CH_ACK);
                n = n + 2'd1;
                phase_nxt = PH_IDLE;
                res[n] = mk_finish(ST_OK, committed_r);
                n = n + 2'd1;
              end else if (b == CH_CAN) begin
                phase_nxt = PH_CANCEL;
              end else if (b == CH_SOH || b == CH_STX) begin
                started_nxt = 1'b1;
                long_nxt = (b == CH_STX);
                pidx_nxt = '0;
                crc_nxt = '0;
                phase_nxt = PH_PACKET;
              end else if (!started_r) begin
                res[n] = mk_tx(CH_C);
                n = n + 2'd1;
              end
            end
            PH_CANCEL: begin
              if (b == CH_CAN) begin
                phase_nxt = PH_IDLE;
                res[n] = mk_finish(ST_CANCEL, committed_r);
                n = n + 2'd1;
              end else begin
                phase_nxt = PH_HEADER;
                idle_nxt = '0;
                if (!started_r) begin
                  res[n] = mk_tx(CH_C);
                  n = n + 2'd1;
                end
              end
            end
            PH_PACKET: begin
              idle_nxt = '0;
              if (pidx_r == 11'd0) begin
                seq_nxt = b;
              end else if (pidx_r == 11'd1) begin
                inv_nxt = b;
              end else if (pidx_r < blk + 11'd2) begin
                crc_nxt = crc_byte(crc_r, b);
                if (addr_full < {1'b0, cap}) begin
                  res[n] = mk_write(addr_full[15:0], b);
                  n = n + 2'd1;
                end
              end else if (pidx_r == blk + 11'd2) begin
                crc_hi_nxt = b;
              end
              if (pidx_r >= blk + 11'd3) begin
                // block complete: check it and answer with ACK, NAK or CAN
                phase_nxt = PH_HEADER;
                if (({1'b0, seq_r} + {1'b0, inv_r}) != 9'h0FF) begin
                  res[n] = mk_tx(CH_NAK);
                  n = n + 2'd1;
                end else if ({crc_hi_r, b} != crc_r) begin
                  res[n] = mk_tx(CH_NAK);
                  n = n + 2'd1;
                end else if (seq_r != exp_seq_r) begin
                  if (seq_r == exp_seq_r - 8'd1) begin
                    res[n] = mk_tx(CH_ACK);
                    n = n + 2'd1;
                  end else begin
                    res[n] = mk_tx(CH_CAN);
                    n = n + 2'd1;
                    res[n] = mk_tx(CH_CAN);
                    n = n + 2'd1;
                    phase_nxt = PH_IDLE;
                    res[n] = mk_finish(ST_SEQ_ERR, committed_r);
                    n = n + 2'd1;
                  end
                end else begin
                  committed_nxt = new_len;
                  exp_seq_nxt = exp_seq_r + 8'd1;
                  retry_nxt = '0;
                  res[n] = mk_tx(CH_ACK);
                  n = n + 2'd1;
                  if (new_len >= cap) begin
                    phase_nxt = PH_IDLE;
                    res[n] = mk_finish(ST_OVERFLOW, new_len);
                    n = n + 2'd1;
                  end
                end
              end else begin
                pidx_nxt = pidx_r + 11'd1;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
    res_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      started_r   <= 1'b0;
      retry_r     <= '0;
      idle_r      <= '0;
      exp_seq_r   <= 8'd1;
      committed_r <= '0;
      long_r      <= 1'b0;
      pidx_r      <= '0;
      seq_r       <= '0;
      inv_r       <= '0;
      crc_r       <= '0;
      crc_hi_r    <= '0;
    end else begin
      phase_r     <= phase_nxt;
      started_r   <= started_nxt;
      retry_r     <= retry_nxt;
      idle_r      <= idle_nxt;
      exp_seq_r   <= exp_seq_nxt;
      committed_r <= committed_nxt;
      long_r      <= long_nxt;
      pidx_r      <= pidx_nxt;
      seq_r       <= seq_nxt;
      inv_r       <= inv_nxt;
      crc_r       <= crc_nxt;
      crc_hi_r    <= crc_hi_nxt;
    end
  end

endmodule

// ----- hdl/xcrc_rq.sv -----
// result queue: takes up to three results a cycle, hands out one per transfer
module xcrc_rq
  import xcrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              push_cnt,
  input  out_item_t [MAX_RES-1:0] push_item,
  output logic                    room,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_item
);

  out_item_t        mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_CW-1:0] count_r;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // space for the worst case of one item, not counting this cycle's pop
  assign room      = (count_r <= RQ_CW'(RQ_DEPTH - MAX_RES));

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (k < int'(push_cnt)) begin
        mem_r[RQ_AW'(wr_ptr_r + RQ_AW'(k))] <= push_item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RQ_AW'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + RQ_CW'(push_cnt) - RQ_CW'(pop);
    end
  end

endmodule

// ----- hdl/xmodem_crc_receiver.sv -----
// top level of the xmodem crc receiver: input stage, config registers, core and result queue
//
// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   in_item_t  (kind, rx_byte)
// out_      output     out_valid / out_stall out_item_t (one result per transfer)
// cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// one input transfer per cycle while in_stall is low; a taken item waits in the staging register
// and is worked once the queue has room; its results are queued and handed out one per output transfer.
// up to three results per item go into an eight-entry result queue; the input stalls while an item
// is staged and the queue has fewer than three free entries.
// reset clears the session state and loads the default register values.
module xmodem_crc_receiver
  import xcrc_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);

  cfg_t                    cfg_r;
  in_item_t                stg_item_r;
  logic                    stg_valid_r;
  logic                    room;
  logic                    proc;
  logic [1:0]              res_cnt;
  out_item_t [MAX_RES-1:0] res;

  assign proc     = stg_valid_r && room;
  assign in_stall = stg_valid_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_capacity      <= 17'd65536;
      cfg_r.byte_timeout_ticks   <= 16'd1000;
      cfg_r.cancel_timeout_ticks <= 16'd500;
      cfg_r.max_retries          <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY:  cfg_r.buffer_capacity      <= cfg_wdata;
        CFG_BYTE_TO:   cfg_r.byte_timeout_ticks   <= cfg_wdata[15:0];
        CFG_CANCEL_TO: cfg_r.cancel_timeout_ticks <= cfg_wdata[15:0];
        CFG_MAX_RETRY: cfg_r.max_retries          <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      stg_valid_r <= 1'b1;
    end else if (proc) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_item_r <= in_item;
    end
  end

  xcrc_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .proc   (proc),
    .item   (stg_item_r),
    .cfg    (cfg_r),
    .res_cnt(res_cnt),
    .res    (res)
  );

  xcrc_rq u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (res_cnt),
    .push_item(res),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule
